[design/bbcc_pkg.sv]
// Shared types and constants for the bounding box collision checker.
package bbcc_pkg;

  // Register file geometry
  localparam int REG_COUNT = 32;
  localparam int ADDR_W    = $clog2(REG_COUNT);

  // Bus access kinds
  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // Address that triggers the overlap test
  localparam logic [ADDR_W-1:0] CHECK_ADDR = ADDR_W'(8'h18);

  // Start-up fix: marker byte and centre adjustment
  localparam logic [7:0] FIX_MARK = 8'hff;
  localparam int         FIX_ADD  = 3;

  // Signed compare width
  localparam int CMP_W = 26;

  // Byte positions, most significant byte first for centres
  localparam logic [ADDR_W-1:0] A_CX_ADDR  = ADDR_W'(8'h01);
  localparam logic [ADDR_W-1:0] A_CX_MARK  = ADDR_W'(8'h04);
  localparam logic [ADDR_W-1:0] A_EX_ADDR  = ADDR_W'(8'h06);
  localparam logic [ADDR_W-1:0] A_EY_ADDR  = ADDR_W'(8'h07);
  localparam logic [ADDR_W-1:0] A_CY_ADDR  = ADDR_W'(8'h09);
  localparam logic [ADDR_W-1:0] A_CY_MARK  = ADDR_W'(8'h0c);
  localparam logic [ADDR_W-1:0] B_EX_ADDR  = ADDR_W'(8'h0e);
  localparam logic [ADDR_W-1:0] B_EY_ADDR  = ADDR_W'(8'h0f);
  localparam logic [ADDR_W-1:0] B_CY_ADDR  = ADDR_W'(8'h11);
  localparam logic [ADDR_W-1:0] B_CX_ADDR  = ADDR_W'(8'h15);

  // Check sequence steps
  localparam logic [1:0] STEP_X_AB = 2'd0;
  localparam logic [1:0] STEP_X_BA = 2'd1;
  localparam logic [1:0] STEP_Y_AB = 2'd2;
  localparam logic [1:0] STEP_Y_BA = 2'd3;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_CHECK = 2'b10
  } state_t;

  // Operands for one edge compare
  typedef struct packed {
    logic [23:0] a_centre;
    logic        a_fix;
    logic [23:0] b_centre;
    logic [7:0]  a_ext;
    logic [7:0]  b_ext;
    logic        a_upper;
  } cmp_op_t;

endpackage

[design/bbcc_axis_cmp.sv]
// Shared edge comparator: tests one box's upper edge against the other's lower edge.
module bbcc_axis_cmp (
  input  bbcc_pkg::cmp_op_t op,
  output logic              apart
);
  import bbcc_pkg::*;

  logic signed [CMP_W-1:0] ca;
  logic signed [CMP_W-1:0] cb;
  logic signed [CMP_W-1:0] esum;
  logic signed [CMP_W-1:0] diff;

  // Upper < lower  <=>  (c_hi - c_lo) + (e_hi + e_lo) < 0, extents stored minus one
  always_comb begin
    ca   = $signed({2'b00, op.a_centre}) + (op.a_fix ? CMP_W'(FIX_ADD) : '0);
    cb   = $signed({2'b00, op.b_centre});
    esum = $signed({{(CMP_W-8){1'b0}}, op.a_ext}) + $signed({{(CMP_W-8){1'b0}}, op.b_ext})
         + CMP_W'(2);
    if (op.a_upper) begin
      diff = ca - cb + esum;
    end else begin
      diff = cb - ca + esum;
    end
    apart = diff[CMP_W-1];
  end

endmodule

[design/bounding_box_collision_checker.sv]
// Top level of the bounding box collision checker.
// A 32-byte register file behind a command port. A write (command 1) with
// low_byte_enable stores one byte; busy stays low, so writes may follow back
// to back, and they give no result. A read at any address but 0x18 returns
// read_value 0 on done, which is registered in the cycle after start. A read
// at 0x18 runs four signed 26-bit edge compares (x and y, each direction)
// through one shared comparator, one compare per cycle; busy is high while
// they run and done pulses after the last one with read_value 1 when the
// boxes are apart. done lasts one cycle and cannot be held off.
// startup_fix_enable is written over the cfg channel while idle.
module bounding_box_collision_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         command,
  input  logic [bbcc_pkg::ADDR_W-1:0]  address,
  input  logic [7:0]                   write_data,
  input  logic                         low_byte_enable,
  output logic                         done,
  output logic                         read_value,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic                         cfg_data
);
  import bbcc_pkg::*;

  logic [7:0]        regs [REG_COUNT];
  logic              fix_en;
  state_t            state;
  logic [1:0]        step;
  logic              sep;
  logic              accept;
  logic              apart;
  cmp_op_t           op;

  assign busy      = (state == ST_CHECK);
  assign accept    = start && !busy;
  assign cfg_ready = !busy;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      fix_en <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      fix_en <= cfg_data;
    end
  end

  // Register file
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        regs[ADDR_W'(i)] <= '0;
      end
    end else if (accept && command == CMD_WRITE && low_byte_enable) begin
      regs[address] <= write_data;
    end
  end

  // Operand select per step
  always_comb begin
    op = '0;
    case (step)
      STEP_X_AB, STEP_X_BA: begin
        op.a_centre = {regs[A_CX_ADDR], regs[A_CX_ADDR + 1'b1], regs[A_CX_ADDR + 2'd2]};
        op.a_fix    = fix_en && (regs[A_CX_MARK] == FIX_MARK);
        op.b_centre = {regs[B_CX_ADDR], regs[B_CX_ADDR + 1'b1], regs[B_CX_ADDR + 2'd2]};
        op.a_ext    = regs[A_EX_ADDR];
        op.b_ext    = regs[B_EX_ADDR];
        op.a_upper  = (step == STEP_X_AB);
      end
      STEP_Y_AB, STEP_Y_BA: begin
        op.a_centre = {regs[A_CY_ADDR], regs[A_CY_ADDR + 1'b1], regs[A_CY_ADDR + 2'd2]};
        op.a_fix    = fix_en && (regs[A_CY_MARK] == FIX_MARK);
        op.b_centre = {regs[B_CY_ADDR], regs[B_CY_ADDR + 1'b1], regs[B_CY_ADDR + 2'd2]};
        op.a_ext    = regs[A_EY_ADDR];
        op.b_ext    = regs[B_EY_ADDR];
        op.a_upper  = (step == STEP_Y_AB);
      end
      default: begin
        op = '0;
      end
    endcase
  end

  bbcc_axis_cmp u_cmp (
    .op    (op),
    .apart (apart)
  );

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      step       <= STEP_X_AB;
      sep        <= 1'b0;
      done       <= 1'b0;
      read_value <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept && command == CMD_READ) begin
            if (address == CHECK_ADDR) begin
              state <= ST_CHECK;
              step  <= STEP_X_AB;
              sep   <= 1'b0;
            end else begin
              done       <= 1'b1;
              read_value <= 1'b0;
            end
          end
        end
        ST_CHECK: begin
          sep  <= sep | apart;
          step <= step + 1'b1;
          if (step == STEP_Y_BA) begin
            state      <= ST_IDLE;
            done       <= 1'b1;
            read_value <= sep | apart;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Checks
  a_no_done_in_check: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CHECK) |-> !done)
    else $error("result strobe during compare sequence");

  a_sep_from_check: assert property (@(posedge clk) disable iff (rst)
    (done && read_value) |-> $past(state == ST_CHECK))
    else $error("separated result without a compare sequence");

  a_step_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (step == STEP_X_AB))
    else $error("step counter not parked while idle");

  a_check_entry: assert property (@(posedge clk) disable iff (rst)
    (accept && command == CMD_READ && address == CHECK_ADDR) |=> (state == ST_CHECK))
    else $error("check read did not start the sequence");

endmodule

[test/bounding_box_collision_checker_tb.sv]
// Self-checking testbench for the bounding box collision checker.
`timescale 1ns / 100ps

module bounding_box_collision_checker_tb;
  import bbcc_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DIR_ROWS     = 25;
  localparam int BOX_BYTES    = 18;
  localparam int BOX_IDX_W    = $clog2(BOX_BYTES);
  localparam int CENTRE_MAX   = 'hff_ffff;
  localparam int PHASE_ITEMS  = 215;
  localparam int PHASES       = 6;
  localparam int SETTLE       = 8;

  // One directed bus access; want is used only where fixed is set
  typedef struct packed {
    logic              cmd;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
    logic              lane;
    logic              fixed;
    logic              want;
  } dir_row_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              start;
  logic              busy;
  logic              command;
  logic [ADDR_W-1:0] address;
  logic [7:0]        write_data;
  logic              low_byte_enable;
  logic              done;
  logic              read_value;
  logic              cfg_valid;
  logic              cfg_ready;
  logic              cfg_data;

  // Predictor state: byte image of the register file and the fix enable
  logic [7:0]  reg_image [REG_COUNT];
  logic        fix_enable_model;
  logic        read_values_due [$];
  logic        no_idle;
  int          errors;
  int          cycle_count;
  int          issued;

  dir_row_t          directed_rows [DIR_ROWS];
  logic [ADDR_W-1:0] box_addrs [BOX_BYTES];
  logic [7:0]        box_vals [BOX_BYTES];

  bounding_box_collision_checker u_dut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .command         (command),
    .address         (address),
    .write_data      (write_data),
    .low_byte_enable (low_byte_enable),
    .done            (done),
    .read_value      (read_value),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Separation test on the current image: apart on x or on y
  function automatic logic predict_apart();
    logic signed [CMP_W-1:0] acx, acy, bcx, bcy, aex, aey, bex, bey;
    acx = $signed({2'b00, reg_image[1], reg_image[2], reg_image[3]});
    acy = $signed({2'b00, reg_image[9], reg_image[10], reg_image[11]});
    bcx = $signed({2'b00, reg_image[21], reg_image[22], reg_image[23]});
    bcy = $signed({2'b00, reg_image[17], reg_image[18], reg_image[19]});
    if (fix_enable_model && reg_image[4] == FIX_MARK) acx = acx + CMP_W'(FIX_ADD);
    if (fix_enable_model && reg_image[12] == FIX_MARK) acy = acy + CMP_W'(FIX_ADD);
    aex = $signed({18'd0, reg_image[6]}) + CMP_W'(1);
    aey = $signed({18'd0, reg_image[7]}) + CMP_W'(1);
    bex = $signed({18'd0, reg_image[14]}) + CMP_W'(1);
    bey = $signed({18'd0, reg_image[15]}) + CMP_W'(1);
    return (acx + aex < bcx - bex) || (bcx + bex < acx - aex) ||
           (acy + aey < bcy - bey) || (bcy + bey < acy - aey);
  endfunction

  // Issue one access after a random gap; on acceptance update the image
  // and queue the expected read value
  task automatic do_access(input logic cmd, input logic [ADDR_W-1:0] addr,
                           input logic [7:0] data, input logic lane,
                           input logic fixed, input logic want);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start           <= 1'b1;
    command         <= cmd;
    address         <= addr;
    write_data      <= data;
    low_byte_enable <= lane;
    do @(posedge clk); while (busy);
    if (cmd == CMD_WRITE) begin
      if (lane) begin
        reg_image[addr] = data;
        issued++;
      end
    end else begin
      issued++;
      if (fixed) read_values_due.push_back(want);
      else if (addr != CHECK_ADDR) read_values_due.push_back(1'b0);
      else read_values_due.push_back(predict_apart());
    end
  endtask

  // Fix enable write, only once the block has drained
  task automatic write_fix_enable(input logic value);
    start <= 1'b0;
    while (read_values_due.size() != 0) @(posedge clk);
    repeat (SETTLE + $urandom_range(0, 14)) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    fix_enable_model = value;
    cfg_valid <= 1'b0;
  endtask

  // Two centres on one axis, mostly near the touching distance
  task automatic pick_pair(input logic [7:0] ea, input logic [7:0] eb,
                           output logic [23:0] ca, output logic [23:0] cb);
    int c, d, o;
    case ($urandom_range(0, 3))
      0: c = 0;
      1: c = CENTRE_MAX;
      default: c = $urandom_range(0, CENTRE_MAX);
    endcase
    if ($urandom_range(0, 9) == 0) d = $urandom_range(0, 2000);
    else d = int'(ea) + int'(eb) + 2 + $urandom_range(0, 10) - 5;
    if ($urandom_range(0, 1)) d = -d;
    o = c + d;
    if (o < 0 || o > CENTRE_MAX) o = c - d;
    if ($urandom_range(0, 1)) begin
      ca = c[23:0];
      cb = o[23:0];
    end else begin
      ca = o[23:0];
      cb = c[23:0];
    end
  endtask

  // Result checker and run limit
  always @(posedge clk) begin
    logic exp_val;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time,
               read_values_due.size());
      $display("bounding_box_collision_checker_tb: FAIL");
      $finish;
    end
    if (!rst && done) begin
      if (read_values_due.size() == 0) begin
        $display("%0t: read_value expected none, actual %0b", $time, read_value);
        errors++;
      end else begin
        exp_val = read_values_due.pop_front();
        if (read_value !== exp_val) begin
          $display("%0t: read_value expected %0b, actual %0b", $time, exp_val,
                   read_value);
          errors++;
        end
      end
    end
  end

  // Stimulus
  initial begin
    logic [7:0]  aex, aey, bex, bey;
    logic [23:0] acx, acy, bcx, bcy;
    logic        cfg_value;
    logic [BOX_IDX_W-1:0] idx, pick;
    int          phase_start, rot, w;

    errors      = 0;
    cycle_count = 0;
    issued      = 0;
    no_idle     = 1'b0;
    rst             = 1'b1;
    start           = 1'b0;
    command         = CMD_READ;
    address         = '0;
    write_data      = '0;
    low_byte_enable = 1'b0;
    cfg_valid       = 1'b0;
    cfg_data        = 1'b0;
    foreach (reg_image[i]) reg_image[i] = 8'h00;
    fix_enable_model = 1'b1;

    box_addrs = '{A_CX_ADDR, ADDR_W'(A_CX_ADDR + 1), ADDR_W'(A_CX_ADDR + 2),
                  A_CY_ADDR, ADDR_W'(A_CY_ADDR + 1), ADDR_W'(A_CY_ADDR + 2),
                  B_CX_ADDR, ADDR_W'(B_CX_ADDR + 1), ADDR_W'(B_CX_ADDR + 2),
                  B_CY_ADDR, ADDR_W'(B_CY_ADDR + 1), ADDR_W'(B_CY_ADDR + 2),
                  A_EX_ADDR, A_EY_ADDR, B_EX_ADDR, B_EY_ADDR,
                  A_CX_MARK, A_CY_MARK};

    // Directed rows, run with the fix enabled as after reset
    directed_rows = '{
      '{CMD_READ,  CHECK_ADDR, 8'h00, 1'b1, 1'b1, 1'b0},  // reset boxes overlap
      '{CMD_READ,  5'h00,      8'h00, 1'b1, 1'b1, 1'b0},  // other address
      '{CMD_READ,  5'h1f,      8'hff, 1'b0, 1'b1, 1'b0},
      '{CMD_WRITE, 5'h1f,      8'hff, 1'b1, 1'b0, 1'b0},
      '{CMD_WRITE, B_CX_ADDR,  8'hff, 1'b0, 1'b0, 1'b0},  // lane off: ignored
      '{CMD_READ,  CHECK_ADDR, 8'h00, 1'b1, 1'b1, 1'b0},
      '{CMD_WRITE, B_CX_ADDR,  8'hff, 1'b1, 1'b0, 1'b0},
      '{CMD_READ,  CHECK_ADDR, 8'h00, 1'b1, 1'b0, 1'b0},
      '{CMD_WRITE, B_CX_ADDR,  8'h00, 1'b1, 1'b0, 1'b0},
      '{CMD_WRITE, A_CX_MARK,  8'hff, 1'b1, 1'b0, 1'b0},  // x centre fix
      '{CMD_READ,  CHECK_ADDR, 8'h5a, 1'b0, 1'b0, 1'b0},  // lane off on read
      '{CMD_WRITE, A_CX_MARK,  8'h00, 1'b1, 1'b0, 1'b0},
      '{CMD_WRITE, A_CY_MARK,  8'hff, 1'b1, 1'b0, 1'b0},  // y centre fix
      '{CMD_READ,  CHECK_ADDR, 8'h00, 1'b1, 1'b0, 1'b0},
      '{CMD_WRITE, A_EY_ADDR,  8'hff, 1'b1, 1'b0, 1'b0},
      '{CMD_READ,  CHECK_ADDR, 8'h00, 1'b1, 1'b0, 1'b0},
      '{CMD_WRITE, A_CY_MARK,  8'hfe, 1'b1, 1'b0, 1'b0},  // one below the mark
      '{CMD_WRITE, A_EX_ADDR,  8'hff, 1'b1, 1'b0, 1'b0},
      '{CMD_WRITE, B_EX_ADDR,  8'hff, 1'b1, 1'b0, 1'b0},
      '{CMD_WRITE, B_EY_ADDR,  8'hff, 1'b1, 1'b0, 1'b0},
      '{CMD_WRITE, A_CX_ADDR,  8'hff, 1'b1, 1'b0, 1'b0},
      '{CMD_READ,  CHECK_ADDR, 8'h00, 1'b1, 1'b0, 1'b0},
      '{CMD_WRITE, B_CY_ADDR,  8'hff, 1'b1, 1'b0, 1'b0},
      '{CMD_READ,  CHECK_ADDR, 8'h00, 1'b1, 1'b0, 1'b0},
      '{CMD_READ,  5'h17,      8'hff, 1'b1, 1'b1, 1'b0}
    };

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      no_idle = (i < 8);
      do_access(directed_rows[i].cmd, directed_rows[i].addr, directed_rows[i].data,
                directed_rows[i].lane, directed_rows[i].fixed, directed_rows[i].want);
    end

    // Random phases, each under its own fix enable setting
    for (int phase = 0; phase < PHASES; phase++) begin
      cfg_value = (phase == 0) ? 1'b0 : (phase == 1) ? 1'b1 : 1'($urandom_range(0, 1));
      write_fix_enable(cfg_value);
      phase_start = issued;
      while (issued - phase_start < PHASE_ITEMS) begin
        no_idle = ($urandom_range(0, 3) == 0);
        case ($urandom_range(0, 19))
          // Full scene: two boxes placed near contact, then the check
          0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: begin
            aex = ($urandom_range(0, 3) == 0) ? 8'hff : 8'($urandom);
            aey = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
            bex = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
            bey = ($urandom_range(0, 3) == 0) ? 8'hff : 8'($urandom);
            pick_pair(aex, bex, acx, bcx);
            pick_pair(aey, bey, acy, bcy);
            box_vals = '{acx[23:16], acx[15:8], acx[7:0],
                         acy[23:16], acy[15:8], acy[7:0],
                         bcx[23:16], bcx[15:8], bcx[7:0],
                         bcy[23:16], bcy[15:8], bcy[7:0],
                         aex, aey, bex, bey,
                         $urandom_range(0, 1) ? 8'hff : 8'($urandom),
                         $urandom_range(0, 1) ? 8'hff : 8'($urandom)};
            rot = $urandom_range(0, BOX_BYTES - 1);
            for (int k = 0; k < BOX_BYTES; k++) begin
              idx = BOX_IDX_W'((k + rot) % BOX_BYTES);
              do_access(CMD_WRITE, box_addrs[idx], box_vals[idx],
                        $urandom_range(0, 9) != 0, 1'b0, 1'b0);
            end
            repeat ($urandom_range(1, 2))
              do_access(CMD_READ, CHECK_ADDR, 8'($urandom), 1'($urandom), 1'b0, 1'b0);
          end
          // Single byte tweak of a box, then the check
          12, 13, 14: begin
            pick = BOX_IDX_W'($urandom_range(0, BOX_BYTES - 1));
            do_access(CMD_WRITE, box_addrs[pick], 8'($urandom), 1'b1, 1'b0, 1'b0);
            do_access(CMD_READ, CHECK_ADDR, 8'($urandom), 1'($urandom), 1'b0, 1'b0);
          end
          // Unconstrained accesses
          default: begin
            repeat ($urandom_range(1, 4))
              do_access(1'($urandom), ADDR_W'($urandom), 8'($urandom), 1'($urandom),
                        1'b0, 1'b0);
          end
        endcase
      end
    end

    // Drain
    start <= 1'b0;
    for (w = 0; w < 200 && read_values_due.size() != 0; w++) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (read_values_due.size() != 0) begin
      $display("%0t: read_value expected %0b, actual none (%0d outstanding)", $time,
               read_values_due[0], read_values_due.size());
      errors++;
    end

    if (errors == 0) begin
      $display("bounding_box_collision_checker_tb: PASS");
    end else begin
      $display("bounding_box_collision_checker_tb: FAIL");
    end
    $finish;
  end

endmodule

[bounding_box_collision_checker.f]
design/bbcc_pkg.sv
design/bbcc_axis_cmp.sv
design/bounding_box_collision_checker.sv
test/bounding_box_collision_checker_tb.sv
